// ----- hw/rtl/psov_pkg.sv -----
// Package: payload types, field widths and constants for the periodic sphere overlap volume block.
`default_nettype none
package psov_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int COORD_W       = 28;
  localparam int RADIUS_W      = 24;
  localparam int BOX_W         = 12;
  localparam int TOL_W         = 16;
  localparam int VOL_W         = 48;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int SUM_W         = RADIUS_W + 1;
  localparam int SQ_W          = 2 * COORD_W;
  localparam int DSQ_W         = SQ_W + 2;
  localparam int SSQ_W         = 2 * SUM_W;
  localparam int ROOT_W        = SUM_W;
  localparam int DEN_W         = ROOT_W + 4;
  localparam int NUM_W         = 72;
  localparam int DIV_STEPS     = VOL_W;
  localparam int PI_W          = 26;
  localparam logic [PI_W-1:0] PI_Q24 = 26'd52707179;
  localparam logic [VOL_W-1:0] VOL_MAX = '1;

  localparam logic [CFG_INDEX_W-1:0] REG_BOX_X = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_Y = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_Z = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOL   = 2'd3;

  localparam logic [BOX_W-1:0] BOX_RESET = 12'd256;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  typedef struct packed {
    logic [COORD_W-1:0]  first_x;
    logic [COORD_W-1:0]  first_y;
    logic [COORD_W-1:0]  first_z;
    logic [RADIUS_W-1:0] first_radius;
    logic [COORD_W-1:0]  second_x;
    logic [COORD_W-1:0]  second_y;
    logic [COORD_W-1:0]  second_z;
    logic [RADIUS_W-1:0] second_radius;
  } in_t;

  typedef struct packed {
    logic [VOL_W-1:0] lens_volume;
    logic             spheres_overlap;
    logic             centres_coincide;
  } out_t;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    abs_diff = (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [COORD_W-1:0] min_image(input logic [COORD_W-1:0] ad,
                                                   input logic [BOX_W-1:0] units);
    logic [COORD_W-1:0] box;
    logic [COORD_W-1:0] wr;
    box = {units, {FRACTION_BITS{1'b0}}};
    wr = abs_diff(box, ad);
    min_image = (wr < ad) ? wr : ad;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/periodic_sphere_overlap_volume.sv -----
// Top level: pipelined lens volume of two spheres in a periodic box.
`default_nettype none
// Takes one transaction per clock: busy is always low and start may be held high
// every cycle. Each result shows on result with done high for one cycle; the
// receiver cannot stall it. Most of the pipeline lies in the 25-stage square root
// and the 48-stage restoring divider.
// Configuration writes must only happen while no transaction is in flight.
module periodic_sphere_overlap_volume (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire psov_pkg::in_t                    item,
  input  wire logic                             cfg_write,
  input  wire logic [psov_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [psov_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                  done,
  output psov_pkg::out_t                        result
);
  import psov_pkg::*;

  logic [BOX_W-1:0] box_x, box_y, box_z;
  logic [TOL_W-1:0] tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x <= BOX_RESET;
      box_y <= BOX_RESET;
      box_z <= BOX_RESET;
      tol   <= TOL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BOX_X: box_x <= cfg_data[BOX_W-1:0];
        REG_BOX_Y: box_y <= cfg_data[BOX_W-1:0];
        REG_BOX_Z: box_z <= cfg_data[BOX_W-1:0];
        REG_TOL:   tol   <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // front end valid bits
  logic v1, v2, v3, v4, v5;
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4} <= '0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 1: axis differences, radius sum and difference
  logic [COORD_W-1:0] ad1_x, ad1_y, ad1_z;
  logic [SUM_W-1:0]   s1;
  logic [RADIUS_W-1:0] dl1;
  always_ff @(posedge clk) begin
    ad1_x <= abs_diff(item.first_x, item.second_x);
    ad1_y <= abs_diff(item.first_y, item.second_y);
    ad1_z <= abs_diff(item.first_z, item.second_z);
    s1    <= SUM_W'(item.first_radius) + SUM_W'(item.second_radius);
    dl1   <= (item.first_radius >= item.second_radius) ?
             item.first_radius - item.second_radius :
             item.second_radius - item.first_radius;
  end

  // stage 2: minimum image
  logic [COORD_W-1:0] m2_x, m2_y, m2_z;
  logic [SUM_W-1:0]   s2;
  logic [RADIUS_W-1:0] dl2;
  always_ff @(posedge clk) begin
    m2_x <= min_image(ad1_x, box_x);
    m2_y <= min_image(ad1_y, box_y);
    m2_z <= min_image(ad1_z, box_z);
    s2   <= s1;
    dl2  <= dl1;
  end

  // stage 3: squares
  logic [SQ_W-1:0]  sq3_x, sq3_y, sq3_z;
  logic [SSQ_W-1:0] ssq3;
  logic [SUM_W-1:0] s3;
  logic [RADIUS_W-1:0] dl3;
  always_ff @(posedge clk) begin
    sq3_x <= m2_x * m2_x;
    sq3_y <= m2_y * m2_y;
    sq3_z <= m2_z * m2_z;
    ssq3  <= s2 * s2;
    s3    <= s2;
    dl3   <= dl2;
  end

  // stage 4: squared distance
  logic [DSQ_W-1:0] dsq4;
  logic [SSQ_W-1:0] ssq4;
  logic [SUM_W-1:0] s4;
  logic [RADIUS_W-1:0] dl4;
  always_ff @(posedge clk) begin
    dsq4 <= DSQ_W'(sq3_x) + DSQ_W'(sq3_y) + DSQ_W'(sq3_z);
    ssq4 <= ssq3;
    s4   <= s3;
    dl4  <= dl3;
  end

  // stage 5: overlap test, feeds square root stage 0
  logic [DSQ_W-1:0] ssq4_ext, margin4;
  logic [DSQ_W-1:0] tol_ext;
  assign ssq4_ext = DSQ_W'(ssq4);
  assign margin4  = ssq4_ext - dsq4;
  assign tol_ext  = DSQ_W'({tol, {FRACTION_BITS{1'b0}}});

  logic [2*ROOT_W:0]   sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]   sq_root [0:ROOT_W];
  logic [SUM_W-1:0]    sq_s    [0:ROOT_W];
  logic [RADIUS_W-1:0] sq_dl   [0:ROOT_W];
  logic                sq_ovl  [0:ROOT_W];
  logic                sq_coin [0:ROOT_W];
  logic                sq_v    [0:ROOT_W];

  always_ff @(posedge clk) begin
    sq_rem[0]  <= (2*ROOT_W+1)'(dsq4[2*ROOT_W-1:0]);
    sq_root[0] <= '0;
    sq_s[0]    <= s4;
    sq_dl[0]   <= dl4;
    sq_coin[0] <= (dsq4 == '0);
    sq_ovl[0]  <= (dsq4 != '0) && (ssq4_ext > dsq4) && (margin4 > tol_ext);
  end
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
  end
  assign sq_v[0] = v5;

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
    localparam int I = ROOT_W - k;
    logic [2*ROOT_W:0] trial;
    assign trial = ((2*ROOT_W+1)'(sq_root[k-1]) << (I + 1)) |
                   ((2*ROOT_W+1)'(1) << (2 * I));
    always_ff @(posedge clk) begin
      if (sq_rem[k-1] >= trial) begin
        sq_rem[k]  <= sq_rem[k-1] - trial;
        sq_root[k] <= sq_root[k-1] | (ROOT_W'(1) << I);
      end else begin
        sq_rem[k]  <= sq_rem[k-1];
        sq_root[k] <= sq_root[k-1];
      end
      sq_s[k]    <= sq_s[k-1];
      sq_dl[k]   <= sq_dl[k-1];
      sq_ovl[k]  <= sq_ovl[k-1];
      sq_coin[k] <= sq_coin[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) sq_v[k] <= 1'b0;
      else     sq_v[k] <= sq_v[k-1];
    end
  end

  // back end: formula terms
  logic [ROOT_W-1:0] d25;
  logic [SUM_W-1:0]  t25;
  assign d25 = sq_root[ROOT_W];
  assign t25 = sq_s[ROOT_W] - d25;

  logic p1_v, p2_v, p3_v, p4_v, p5_v, p6_v, p7_v;
  always_ff @(posedge clk) begin
    if (rst) begin
      {p1_v, p2_v, p3_v, p4_v, p5_v, p6_v} <= '0;
    end else begin
      p1_v <= sq_v[ROOT_W];
      p2_v <= p1_v;
      p3_v <= p2_v;
      p4_v <= p3_v;
      p5_v <= p4_v;
      p6_v <= p5_v;
    end
  end

  logic [SSQ_W-1:0]      tt1, dd1, ds1;
  logic [2*RADIUS_W-1:0] dl2_1;
  logic [DEN_W-1:0]      den1;
  logic                  ovl1, coin1;
  always_ff @(posedge clk) begin
    tt1   <= t25 * t25;
    dd1   <= d25 * d25;
    ds1   <= d25 * sq_s[ROOT_W];
    dl2_1 <= sq_dl[ROOT_W] * sq_dl[ROOT_W];
    den1  <= (DEN_W'(d25) << 3) + (DEN_W'(d25) << 2);
    ovl1  <= sq_ovl[ROOT_W];
    coin1 <= sq_coin[ROOT_W];
  end

  localparam int POS_W = SSQ_W + 2;
  logic [POS_W-1:0] pos1, neg1;
  assign pos1 = POS_W'(dd1) + (POS_W'(ds1) << 1);
  assign neg1 = (POS_W'(dl2_1) << 1) + POS_W'(dl2_1);

  logic [POS_W-1:0] diff2;
  logic [SSQ_W-1:0] tt2;
  logic [DEN_W-1:0] den2;
  logic             pgt2, ovl2, coin2;
  always_ff @(posedge clk) begin
    diff2 <= pos1 - neg1;
    pgt2  <= pos1 > neg1;
    tt2   <= tt1;
    den2  <= den1;
    ovl2  <= ovl1;
    coin2 <= coin1;
  end

  localparam int H = 26;
  logic [2*H-1:0]   pp00, pp01, pp10, pp11;
  logic [DEN_W-1:0] den3;
  logic             pgt3, ovl3, coin3;
  always_ff @(posedge clk) begin
    pp00  <= tt2[H-1:0] * diff2[H-1:0];
    pp01  <= tt2[H-1:0] * diff2[POS_W-1:H];
    pp10  <= (2*H)'(tt2[SSQ_W-1:H]) * diff2[H-1:0];
    pp11  <= (2*H)'(tt2[SSQ_W-1:H]) * diff2[POS_W-1:H];
    den3  <= den2;
    pgt3  <= pgt2;
    ovl3  <= ovl2;
    coin3 <= coin2;
  end

  localparam int PROD_W = SSQ_W + POS_W;
  logic [PROD_W-1:0] prod4;
  logic [DEN_W-1:0]  den4;
  logic              pgt4, ovl4, coin4;
  always_ff @(posedge clk) begin
    prod4 <= PROD_W'(pp00) + (PROD_W'(pp01) << H) + (PROD_W'(pp10) << H) +
             (PROD_W'(pp11) << (2 * H));
    den4  <= den3;
    pgt4  <= pgt3;
    ovl4  <= ovl3;
    coin4 <= coin3;
  end

  logic [H+PI_W-1:0] q5_0, q5_1, q5_2, q5_3;
  logic [DEN_W-1:0]  den5;
  logic              pgt5, ovl5, coin5;
  always_ff @(posedge clk) begin
    q5_0  <= prod4[H-1:0] * PI_Q24;
    q5_1  <= prod4[2*H-1:H] * PI_Q24;
    q5_2  <= prod4[3*H-1:2*H] * PI_Q24;
    q5_3  <= (H+PI_W)'(prod4[PROD_W-1:3*H]) * PI_Q24;
    den5  <= den4;
    pgt5  <= pgt4;
    ovl5  <= ovl4;
    coin5 <= coin4;
  end

  localparam int N_W = 128;
  logic [N_W-1:0] n5;
  assign n5 = N_W'(q5_0) + (N_W'(q5_1) << H) + (N_W'(q5_2) << (2 * H)) +
              (N_W'(q5_3) << (3 * H));

  logic [NUM_W-1:0] num6;
  logic [DEN_W-1:0] den6;
  logic             pgt6, ovl6, coin6;
  always_ff @(posedge clk) begin
    num6  <= n5[N_W-1:N_W-NUM_W];
    den6  <= den5;
    pgt6  <= pgt5;
    ovl6  <= ovl5;
    coin6 <= coin5;
  end

  // divider: quotient bits beyond the volume width mean saturation
  localparam int REM_W = DEN_W + 1;

  logic [REM_W-1:0]     dv_rem  [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_low  [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_q    [0:DIV_STEPS];
  logic [DEN_W-1:0]     dv_den  [0:DIV_STEPS];
  logic                 dv_sat  [0:DIV_STEPS];
  logic                 dv_pgt  [0:DIV_STEPS];
  logic                 dv_ovl  [0:DIV_STEPS];
  logic                 dv_coin [0:DIV_STEPS];
  logic                 dv_v    [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    dv_rem[0]  <= REM_W'(num6[NUM_W-1:DIV_STEPS]);
    dv_low[0]  <= num6[DIV_STEPS-1:0];
    dv_q[0]    <= '0;
    dv_den[0]  <= den6;
    dv_sat[0]  <= DEN_W'(num6[NUM_W-1:DIV_STEPS]) >= den6;
    dv_pgt[0]  <= pgt6;
    dv_ovl[0]  <= ovl6;
    dv_coin[0] <= coin6;
  end
  always_ff @(posedge clk) begin
    if (rst) p7_v <= 1'b0;
    else     p7_v <= p6_v;
  end
  assign dv_v[0] = p7_v;

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [REM_W-1:0] r;
    assign r = {dv_rem[k-1][REM_W-2:0], dv_low[k-1][DIV_STEPS-1]};
    always_ff @(posedge clk) begin
      if (r >= REM_W'(dv_den[k-1])) begin
        dv_rem[k] <= r - REM_W'(dv_den[k-1]);
        dv_q[k]   <= {dv_q[k-1][DIV_STEPS-2:0], 1'b1};
      end else begin
        dv_rem[k] <= r;
        dv_q[k]   <= {dv_q[k-1][DIV_STEPS-2:0], 1'b0};
      end
      dv_low[k]  <= dv_low[k-1] << 1;
      dv_den[k]  <= dv_den[k-1];
      dv_sat[k]  <= dv_sat[k-1];
      dv_pgt[k]  <= dv_pgt[k-1];
      dv_ovl[k]  <= dv_ovl[k-1];
      dv_coin[k] <= dv_coin[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) dv_v[k] <= 1'b0;
      else     dv_v[k] <= dv_v[k-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_v[DIV_STEPS];
  end
  always_ff @(posedge clk) begin
    result.spheres_overlap  <= dv_ovl[DIV_STEPS];
    result.centres_coincide <= dv_coin[DIV_STEPS];
    if (!dv_ovl[DIV_STEPS] || !dv_pgt[DIV_STEPS])
      result.lens_volume <= '0;
    else if (dv_sat[DIV_STEPS])
      result.lens_volume <= VOL_MAX;
    else
      result.lens_volume <= dv_q[DIV_STEPS];
  end

endmodule
`default_nettype wire

// ----- sim/tb_periodic_sphere_overlap_volume.sv -----
// Testbench for the periodic sphere overlap volume block: directed table, random pairs, scoreboard.
`default_nettype none
module tb_periodic_sphere_overlap_volume;
  timeunit 1ns;
  timeprecision 1ps;
  import psov_pkg::*;

  typedef struct {
    in_t  stim;
    bit   known;
    out_t want;
  } lens_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_t  item = '0;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic busy;
  logic done;
  out_t result;

  logic [BOX_W-1:0] box_x_units, box_y_units, box_z_units;
  logic [TOL_W-1:0] margin_tol;
  out_t pending_lens[$];
  lens_row_t directed_rows[$];
  int errors = 0;
  int lens_checked = 0;
  int overlap_seen = 0;
  int coincide_seen = 0;

  always #1 clk = ~clk;

  periodic_sphere_overlap_volume DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned axis_sep_sq(longint unsigned a, longint unsigned b,
                                                  longint unsigned units);
    longint unsigned span, ad, wr, m;
    span = units << FRACTION_BITS;
    ad = (a >= b) ? a - b : b - a;
    wr = (span >= ad) ? span - ad : ad - span;
    m = (wr < ad) ? wr : ad;
    return m * m;
  endfunction

  function automatic out_t lens_volume_predict(in_t p);
    longint unsigned r1, r2, dsq, s, ssq, tol, d, t, dl, pos, neg;
    logic [127:0] n;
    out_t o;
    o = '0;
    r1 = 64'(p.first_radius);
    r2 = 64'(p.second_radius);
    dsq = axis_sep_sq(64'(p.first_x), 64'(p.second_x), 64'(box_x_units))
        + axis_sep_sq(64'(p.first_y), 64'(p.second_y), 64'(box_y_units))
        + axis_sep_sq(64'(p.first_z), 64'(p.second_z), 64'(box_z_units));
    s = r1 + r2;
    ssq = s * s;
    tol = 64'(margin_tol) << FRACTION_BITS;
    if (dsq == 0) begin
      o.centres_coincide = 1'b1;
    end else if (ssq > dsq && ssq - dsq > tol) begin
      d = floor_root(dsq);
      t = s - d;
      dl = (r1 >= r2) ? r1 - r2 : r2 - r1;
      pos = d * d + 2 * d * s;
      neg = 3 * dl * dl;
      o.spheres_overlap = 1'b1;
      if (pos > neg) begin
        n = 128'(t * t) * 128'(pos - neg);
        n = n * 128'(PI_Q24);
        n = n / 128'(12 * d);
        n = n >> (2 * FRACTION_BITS + 24);
        o.lens_volume = (n > 128'(VOL_MAX)) ? VOL_MAX : n[VOL_W-1:0];
      end
    end
    return o;
  endfunction

  function automatic in_t pair(longint unsigned x1, longint unsigned y1, longint unsigned z1,
                               longint unsigned r1, longint unsigned x2, longint unsigned y2,
                               longint unsigned z2, longint unsigned r2);
    in_t p;
    p.first_x = COORD_W'(x1);  p.first_y = COORD_W'(y1);  p.first_z = COORD_W'(z1);
    p.first_radius = RADIUS_W'(r1);
    p.second_x = COORD_W'(x2); p.second_y = COORD_W'(y2); p.second_z = COORD_W'(z2);
    p.second_radius = RADIUS_W'(r2);
    return p;
  endfunction

  function automatic out_t lens_out(logic [VOL_W-1:0] v, logic ov, logic co);
    out_t o;
    o.lens_volume = v;
    o.spheres_overlap = ov;
    o.centres_coincide = co;
    return o;
  endfunction

  function automatic void add_row(in_t stim, bit known, out_t want);
    lens_row_t r;
    r.stim = stim;
    r.known = known;
    r.want = want;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // caller drops cfg_write after the last write
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_BOX_X: box_x_units = val[BOX_W-1:0];
      REG_BOX_Y: box_y_units = val[BOX_W-1:0];
      REG_BOX_Z: box_z_units = val[BOX_W-1:0];
      REG_TOL: margin_tol = val;
      default: ;
    endcase
  endtask

  task automatic drain_pipe();
    while (pending_lens.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  // one transaction; start stays high if no gap follows
  task automatic send_pair(in_t p, bit known, out_t want, int gap);
    start <= 1'b1;
    item <= p;
    do @(posedge clk); while (busy);
    pending_lens.insert(pending_lens.size(), known ? want : lens_volume_predict(p));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_t random_pair();
    in_t p;
    longint unsigned r1, r2, reach;
    int sh;
    if ($urandom_range(0, 3) == 0) begin
      p = pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom);
      return p;
    end
    sh = $urandom_range(4, 24);
    r1 = $urandom & ((64'd1 << sh) - 1);
    r2 = $urandom & ((64'd1 << $urandom_range(4, 24)) - 1);
    reach = r1 + r2 + 1;
    p.first_x = COORD_W'($urandom);
    p.first_y = COORD_W'($urandom);
    p.first_z = COORD_W'($urandom);
    p.first_radius = RADIUS_W'(r1);
    p.second_radius = RADIUS_W'(r2);
    p.second_x = COORD_W'(64'(p.first_x) + ($urandom % reach) - reach / 2);
    p.second_y = COORD_W'(64'(p.first_y) + ($urandom % reach) - reach / 2);
    p.second_z = COORD_W'(64'(p.first_z) + ($urandom % reach) - reach / 2);
    if ($urandom_range(0, 7) == 0) p.second_x = p.first_x;
    return p;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_lens.size() == 0) begin
        $error("unexpected result: lens_volume %0h", result.lens_volume);
        errors++;
      end else begin
        out_t exp_o;
        exp_o = pending_lens.pop_front();
        lens_checked++;
        if (exp_o.spheres_overlap) overlap_seen++;
        if (exp_o.centres_coincide) coincide_seen++;
        if (result.lens_volume !== exp_o.lens_volume) begin
          $error("lens_volume exp %0h got %0h", exp_o.lens_volume, result.lens_volume);
          errors++;
        end
        if (result.spheres_overlap !== exp_o.spheres_overlap) begin
          $error("spheres_overlap exp %0b got %0b", exp_o.spheres_overlap,
                 result.spheres_overlap);
          errors++;
        end
        if (result.centres_coincide !== exp_o.centres_coincide) begin
          $error("centres_coincide exp %0b got %0b", exp_o.centres_coincide,
                 result.centres_coincide);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_periodic_sphere_overlap_volume NOT OK");
    $finish;
  end

  initial begin
    localparam longint unsigned U = 64'd1 << FRACTION_BITS;
    logic [CFG_DATA_W-1:0] settings[5][4];
    int burst;
    lens_row_t row;
    box_x_units = BOX_RESET;
    box_y_units = BOX_RESET;
    box_z_units = BOX_RESET;
    margin_tol = TOL_RESET;
    settings = '{'{16'd256, 16'd256, 16'd256, 16'd1},
                 '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                 '{16'hF000, 16'd0, 16'd1, 16'd0},
                 '{16'd1, 16'd4095, 16'd7, 16'd300},
                 '{16'd40, 16'd2048, 16'd100, 16'd3}};

    // reset-state rows, extremes and known special cases
    add_row('0, 1'b1, lens_out('0, 1'b0, 1'b1));
    add_row('1, 1'b1, lens_out('0, 1'b0, 1'b1));
    add_row(pair(0, 0, 0, U, 100 * U, 0, 0, U), 1'b1, lens_out('0, 1'b0, 1'b0));
    add_row(pair(5 * U, 5 * U, 5 * U, 10 * U, 6 * U, 5 * U, 5 * U, U), 1'b1,
            lens_out('0, 1'b1, 1'b0));
    add_row(pair(0, 0, 0, 24'hFFFFFF, U, 0, 0, 24'hFFFFFF), 1'b0, '0);
    add_row(pair(0, 0, 0, U, 255 * U + U / 2, 0, 0, U), 1'b0, '0);
    add_row(pair(10 * U, 10 * U, 10 * U, 2 * U, 11 * U, 10 * U, 10 * U, 2 * U), 1'b0, '0);
    add_row(pair(28'hFFFFFFF, 0, 28'hFFFFFFF, 3 * U, 0, 28'hFFFFFFF, 0, 3 * U), 1'b0, '0);
    add_row(pair(0, 0, 0, U / 2, 1, 0, 0, U / 2), 1'b0, '0);
    add_row(pair(0, 0, 0, 0, 1, 0, 0, 0), 1'b1, lens_out('0, 1'b0, 1'b0));
    add_row(pair(7 * U, 0, 0, 24'hFFFFFF, 7 * U, 1, 0, 0), 1'b0, '0);
    add_row(pair(300 * U, 0, 0, U, 44 * U, 0, 0, U), 1'b1, lens_out('0, 1'b0, 1'b1));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_pair(row.stim, row.known, row.want, $urandom_range(0, 3));
    end

    for (int ph = 0; ph < 5; ph++) begin
      start <= 1'b0;
      drain_pipe();
      for (int k = 0; k < 4; k++) write_reg(k[CFG_INDEX_W-1:0], settings[ph][k]);
      cfg_write <= 1'b0;
      burst = 0;
      for (int n = 0; n < 180; n++) begin
        if (burst == 0 && $urandom_range(0, 9) == 0) burst = $urandom_range(5, 30);
        if (burst > 0) burst--;
        send_pair(random_pair(), 0, '0, (burst > 0) ? 0 : $urandom_range(0, 8));
      end
    end
    start <= 1'b0;
    while (pending_lens.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d results over 5 register settings: %0d overlapping, %0d coincident",
             lens_checked, overlap_seen, coincide_seen);
    if (errors == 0) begin
      $display("tb_periodic_sphere_overlap_volume OK");
    end else begin
      $display("tb_periodic_sphere_overlap_volume NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
